// File: design/bank_switch_irq_mapper_defines.svh
// Assertion macros used by the mapper top module.
// Needs a clk and an active-low rst_n in the scope where a macro is used.
`ifndef BANK_SWITCH_IRQ_MAPPER_DEFINES_SVH
`define BANK_SWITCH_IRQ_MAPPER_DEFINES_SVH

// Checked only while out of reset.
`define BSIM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define BSIM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bsim_pkg.sv
// Types and constants of the bank-switching IRQ mapper.
// No dependencies; used by the mapper top and bsim_core.
package bsim_pkg;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // CPU address regions (A15..A12)
  localparam logic [3:0] REGION_PRG16 = 4'h8;
  localparam logic [3:0] REGION_SND1  = 4'h9;
  localparam logic [3:0] REGION_SND2  = 4'hA;
  localparam logic [3:0] REGION_SND3  = 4'hB;
  localparam logic [3:0] REGION_PRG8  = 4'hC;
  localparam logic [3:0] REGION_CHR0  = 4'hD;
  localparam logic [3:0] REGION_CHR1  = 4'hE;
  localparam logic [3:0] REGION_IRQ   = 4'hF;

  // register selects after the optional swap
  localparam logic [1:0] SEL_BANK      = 2'd0;
  localparam logic [1:0] SEL_SWAP_A    = 2'd1;
  localparam logic [1:0] SEL_SWAP_B    = 2'd2;
  localparam logic [1:0] SEL_MIRROR    = 2'd3;
  localparam logic [1:0] IRQ_SEL_LATCH = 2'd0;
  localparam logic [1:0] IRQ_SEL_CTRL  = 2'd1;
  localparam logic [1:0] IRQ_SEL_ACK   = 2'd2;

  // IRQ control bits
  localparam int IRQ_CTL_AUTO  = 0;
  localparam int IRQ_CTL_EN    = 1;
  localparam int IRQ_CTL_CYCLE = 2;

  localparam int          PRESCALE_W    = 10;
  localparam logic [PRESCALE_W-1:0] PRESCALE_LOAD = 10'd341;
  localparam logic [PRESCALE_W-1:0] PRESCALE_STEP = 10'd3;

  localparam logic [7:0] PRG_B_RESET = 8'hFE;
  localparam logic [7:0] COUNT_TOP   = 8'hFF;
  localparam int         CHR_SLOTS   = 8;

  typedef struct packed {
    logic       req_type;
    logic [3:0] addr_region;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } bsim_item_t;

  typedef struct packed {
    logic [7:0]  prg_bank_16k;
    logic [7:0]  prg_bank_8k;
    logic [63:0] chr_banks;
    logic [1:0]  mirror_mode;
    logic        irq_asserted;
    logic        sound_write_valid;
    logic [15:0] sound_address;
    logic [7:0]  sound_data;
  } bsim_result_t;

endpackage

// File: design/bsim_in_if.sv
// Input channel of the mapper: CPU writes and cycle ticks.
// Depends on nothing; field widths follow bsim_pkg.
interface bsim_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [3:0] addr_region;
  logic [1:0] reg_select;
  logic [7:0] write_data;

  modport source (output valid, req_type, addr_region, reg_select, write_data,
                  input ready);
  modport sink (input valid, req_type, addr_region, reg_select, write_data,
                output ready);
endinterface

// File: design/bsim_out_if.sv
// Result channel of the mapper: banking state, IRQ line, sound write.
// Depends on nothing; field widths follow bsim_pkg.
interface bsim_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  prg_bank_16k;
  logic [7:0]  prg_bank_8k;
  logic [63:0] chr_banks;
  logic [1:0]  mirror_mode;
  logic        irq_asserted;
  logic        sound_write_valid;
  logic [15:0] sound_address;
  logic [7:0]  sound_data;

  modport source (output valid, prg_bank_16k, prg_bank_8k, chr_banks, mirror_mode,
                  irq_asserted, sound_write_valid, sound_address, sound_data,
                  input ready);
  modport sink (input valid, prg_bank_16k, prg_bank_8k, chr_banks, mirror_mode,
                irq_asserted, sound_write_valid, sound_address, sound_data,
                output ready);
endinterface

// File: design/bank_switch_irq_mapper.sv
//  channel | dir | handshake      | carries
//  in_ch   | in  | valid / ready  | req_type, addr_region, reg_select, write_data
//  out_ch  | out | valid / ready  | banks, mirroring, IRQ line, sound write
//  cfg_*   | in  | cfg_we         | swap_a0_a1 (cfg_wdata)
// One item per cycle sustained while out_ch.ready allows: input register, one pass of
// decode/timer logic, result register. out_ch.valid rises once the item leaves the input register.
// A stalled result holds; the input register still takes one item behind it.
// Reset (synchronous, rst_n low) restores the power-on bank and timer state.
`include "bank_switch_irq_mapper_defines.svh"
module bank_switch_irq_mapper
  import bsim_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  bsim_in_if.sink   in_ch,
  bsim_out_if.source out_ch,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);

  logic         s1_valid_r, s1_valid_nxt;
  bsim_item_t   s1_item_r;
  logic         out_valid_r, out_valid_nxt;
  bsim_result_t out_r;
  bsim_result_t core_result;
  logic         in_acc;
  logic         adv;

  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_acc || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ch.ready);

  bsim_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (adv),
    .item      (s1_item_r),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (in_acc) begin
      s1_item_r.req_type    <= in_ch.req_type;
      s1_item_r.addr_region <= in_ch.addr_region;
      s1_item_r.reg_select  <= in_ch.reg_select;
      s1_item_r.write_data  <= in_ch.write_data;
    end
    if (adv) out_r <= core_result;
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.prg_bank_16k      = out_r.prg_bank_16k;
  assign out_ch.prg_bank_8k       = out_r.prg_bank_8k;
  assign out_ch.chr_banks         = out_r.chr_banks;
  assign out_ch.mirror_mode       = out_r.mirror_mode;
  assign out_ch.irq_asserted      = out_r.irq_asserted;
  assign out_ch.sound_write_valid = out_r.sound_write_valid;
  assign out_ch.sound_address     = out_r.sound_address;
  assign out_ch.sound_data        = out_r.sound_data;

  `BSIM_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !s1_valid_r && !out_valid_r, "pipeline not empty after reset")
  `BSIM_ASSERT(a_accept_lands, in_acc |=> s1_valid_r, "accepted item missing from input register")
  `BSIM_ASSERT(a_stall_keeps, s1_valid_r && out_valid_r && !out_ch.ready |=> s1_valid_r, "item dropped while output stalled")
  `BSIM_ASSERT(a_snd_region, out_ch.valid && out_ch.sound_write_valid |-> out_ch.sound_address[15:12] == REGION_SND1 || out_ch.sound_address[15:12] == REGION_SND2 || out_ch.sound_address[15:12] == REGION_SND3, "sound write outside sound regions")

endmodule

// File: design/bsim_core.sv
// Mapper register file, write decoder and IRQ timer.
// Depends on bsim_pkg; the result is combinational from the state after the item.
module bsim_core
  import bsim_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic         cfg_wdata,
  input  logic         step,
  input  bsim_item_t   item,
  output bsim_result_t result
);

  logic                  swap_r;
  logic [7:0]            prg_a_r, prg_a_nxt;
  logic [7:0]            prg_b_r, prg_b_nxt;
  logic [7:0]            chr_r   [CHR_SLOTS];
  logic [7:0]            chr_nxt [CHR_SLOTS];
  logic [1:0]            mirror_r, mirror_nxt;
  logic [2:0]            ctl_r, ctl_nxt;
  logic [7:0]            cnt_r, cnt_nxt;
  logic [7:0]            reload_r, reload_nxt;
  logic [PRESCALE_W-1:0] presc_r, presc_nxt;
  logic                  line_r, line_nxt;

  logic [1:0] sel_sw;
  logic       cnt_clk;
  logic       snd_valid;

  // boards with A0/A1 exchanged swap selects 1 and 2
  assign sel_sw = (swap_r && (item.reg_select == SEL_SWAP_A ||
                              item.reg_select == SEL_SWAP_B)) ?
                  ~item.reg_select : item.reg_select;

  always_comb begin
    prg_a_nxt  = prg_a_r;
    prg_b_nxt  = prg_b_r;
    chr_nxt    = chr_r;
    mirror_nxt = mirror_r;
    ctl_nxt    = ctl_r;
    cnt_nxt    = cnt_r;
    reload_nxt = reload_r;
    presc_nxt  = presc_r;
    line_nxt   = line_r;
    cnt_clk    = 1'b0;
    snd_valid  = 1'b0;

    if (item.req_type == REQ_TICK) begin
      if (ctl_r[IRQ_CTL_EN]) begin
        if (ctl_r[IRQ_CTL_CYCLE]) begin
          cnt_clk = 1'b1;
        end else if (presc_r < PRESCALE_STEP) begin
          presc_nxt = presc_r + (PRESCALE_LOAD - PRESCALE_STEP);
          cnt_clk   = 1'b1;
        end else begin
          presc_nxt = presc_r - PRESCALE_STEP;
        end
      end
      if (cnt_clk) begin
        if (cnt_r == COUNT_TOP) begin
          cnt_nxt  = reload_r;
          line_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
        end
      end
    end else begin
      case (item.addr_region)
        REGION_PRG16: begin
          if (sel_sw == SEL_BANK) prg_a_nxt = item.write_data;
        end
        REGION_SND1, REGION_SND2: begin
          snd_valid = 1'b1;
        end
        REGION_SND3: begin
          if (sel_sw == SEL_MIRROR) mirror_nxt = item.write_data[3:2];
          else snd_valid = 1'b1;
        end
        REGION_PRG8: begin
          if (sel_sw == SEL_BANK) prg_b_nxt = item.write_data;
        end
        REGION_CHR0: begin
          chr_nxt[{1'b0, sel_sw}] = item.write_data;
        end
        REGION_CHR1: begin
          chr_nxt[{1'b1, sel_sw}] = item.write_data;
        end
        REGION_IRQ: begin
          case (sel_sw)
            IRQ_SEL_LATCH: begin
              reload_nxt = item.write_data;
            end
            IRQ_SEL_CTRL: begin
              ctl_nxt  = item.write_data[2:0];
              line_nxt = 1'b0;
              if (item.write_data[IRQ_CTL_EN]) begin
                cnt_nxt   = reload_r;
                presc_nxt = PRESCALE_LOAD;
              end
            end
            IRQ_SEL_ACK: begin
              ctl_nxt[IRQ_CTL_EN] = ctl_r[IRQ_CTL_AUTO];
              line_nxt            = 1'b0;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.prg_bank_16k = prg_a_nxt;
    result.prg_bank_8k  = prg_b_nxt;
    for (int i = 0; i < CHR_SLOTS; i++) begin
      result.chr_banks[8*i +: 8] = chr_nxt[i];
    end
    result.mirror_mode       = mirror_nxt;
    result.irq_asserted      = line_nxt;
    result.sound_write_valid = snd_valid;
    result.sound_address     = snd_valid ? {item.addr_region, 10'd0, sel_sw} : 16'd0;
    result.sound_data        = snd_valid ? item.write_data : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_r   <= 1'b0;
      prg_a_r  <= 8'd0;
      prg_b_r  <= PRG_B_RESET;
      for (int i = 0; i < CHR_SLOTS; i++) begin
        chr_r[i] <= 8'(i);
      end
      mirror_r <= 2'd0;
      ctl_r    <= 3'd0;
      cnt_r    <= 8'd0;
      reload_r <= 8'd0;
      presc_r  <= PRESCALE_LOAD;
      line_r   <= 1'b0;
    end else begin
      if (cfg_we) swap_r <= cfg_wdata;
      if (step) begin
        prg_a_r  <= prg_a_nxt;
        prg_b_r  <= prg_b_nxt;
        chr_r    <= chr_nxt;
        mirror_r <= mirror_nxt;
        ctl_r    <= ctl_nxt;
        cnt_r    <= cnt_nxt;
        reload_r <= reload_nxt;
        presc_r  <= presc_nxt;
        line_r   <= line_nxt;
      end
    end
  end

endmodule
